### src/vtc_pkg.sv
// shared types, constants and binary32 arithmetic helpers for the vertex transform
`timescale 1ns / 1ps
package vtc_pkg;

  localparam logic [31:0] QNAN        = 32'h7FC0_0000;
  localparam int          NUM_REGS    = 8;
  localparam int          LANES       = 4;
  localparam int          LANE_STAGES = 4;
  localparam int          DIV_STEPS   = 27;
  localparam int          DIV_LAT     = DIV_STEPS + 2;
  localparam int          LATENCY     = LANE_STAGES + DIV_LAT;

  localparam logic [63:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
  };

  typedef enum logic [1:0] {
    MODE_POINT  = 2'd0,
    MODE_DIVIDE = 2'd1,
    MODE_DIR    = 2'd2,
    MODE_FULL   = 2'd3
  } mode_e;

  // normalize, denormalize, round to nearest even and pack; bit 49 of m is the unit position
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e_in,
                                           input logic [49:0] m_in);
    logic [49:0]        m;
    logic signed [11:0] e;
    logic [5:0]         lz;
    logic               found;
    logic [11:0]        sh;
    logic               guard;
    logic               sticky;
    logic [24:0]        man_r;
    logic [31:0]        r;
    m      = m_in;
    e      = e_in;
    lz     = '0;
    found  = 1'b0;
    sticky = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    m = m << lz;
    e = e - $signed({6'b0, lz});
    if (e < 1) begin
      sh = 12'(1 - e);
      for (int i = 0; i < 50; i++) begin
        if (i < int'(sh)) sticky = sticky | m[i];
      end
      m = (sh >= 12'd50) ? 50'b0 : (m >> sh);
      e = 12'sd1;
    end
    guard  = m[25];
    sticky = sticky | (|m[24:0]);
    man_r  = {1'b0, m[49:26]} + 25'(guard & (sticky | m[26]));
    if (man_r[24]) begin
      man_r = man_r >> 1;
      e     = e + 12'sd1;
    end
    if (m_in == 50'b0) r = {sgn, 31'b0};
    else if (e >= 255) r = {sgn, 8'hFF, 23'b0};
    else if (!man_r[23]) r = {sgn, 8'h00, man_r[22:0]};
    else r = {sgn, e[7:0], man_r[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0]         exa, exb;
    logic [47:0]        prod;
    logic signed [11:0] e;
    logic [31:0]        r;
    s      = a[31] ^ b[31];
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    zero_a = a[30:0] == 31'b0;
    zero_b = b[30:0] == 31'b0;
    exa    = (a[30:23] == 8'h00) ? 8'd1 : a[30:23];
    exb    = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
    prod   = {24'b0, (a[30:23] != 8'h00), a[22:0]} * {24'b0, (b[30:23] != 8'h00), b[22:0]};
    e      = $signed({4'b0, exa}) + $signed({4'b0, exb}) - 12'sd126;
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) r = QNAN;
    else if (inf_a || inf_b) r = {s, 8'hFF, 23'b0};
    else if (zero_a || zero_b) r = {s, 31'b0};
    else r = fp_round(s, e, {prod, 2'b0});
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [49:0] mb, ms, sm, sum;
    logic        sticky;
    logic [31:0] r;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb     = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    es     = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
    d      = eb - es;
    mb     = {1'b0, (big[30:23] != 8'h00), big[22:0], 25'b0};
    ms     = {1'b0, (sml[30:23] != 8'h00), sml[22:0], 25'b0};
    sticky = 1'b0;
    for (int i = 0; i < 50; i++) begin
      if (i < int'(d)) sticky = sticky | ms[i];
    end
    sm  = ((d >= 8'd50) ? 50'b0 : (ms >> d)) | {49'b0, sticky};
    sum = (a[31] ^ b[31]) ? (mb - sm) : (mb + sm);
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) r = QNAN;
    else if (inf_a) r = a;
    else if (inf_b) r = b;
    else if ((a[30:0] == 31'b0) && (b[30:0] == 31'b0)) r = {a[31] & b[31], 31'b0};
    else r = fp_round((sum == 50'b0) ? 1'b0 : big[31], $signed({4'b0, eb}) + 12'sd1, sum);
    return r;
  endfunction

endpackage

### src/vertex_transform_core.sv
// vertex transform top level: matrix registers, lane array, merge and flow control
// a request passes 4 lane stages and 29 merge stages between acceptance and result valid
// throughput: one request per cycle; the whole pipeline holds while a result waits
// the merge stage divider takes one quotient bit per stage, which sets its depth
// reset: asynchronous active low; clears valid flags and loads the identity matrix
`timescale 1ns / 1ps
module vertex_transform_core import vtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  input  logic [31:0] in_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] out_w_o
);

  logic [63:0]  cfg_q [NUM_REGS];
  logic [LATENCY-1:0] vld_q;
  logic         en;
  logic [31:0]  col [LANES];
  mode_e        lane_mode [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) cfg_q[k] <= CFG_RESET[k];
    end else if (psel && penable && pwrite) begin
      cfg_q[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = cfg_q[paddr[5:3]];
  assign pready = 1'b1;

  assign en = !vld_q[LATENCY-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LATENCY-1];

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    vtc_lane u_lane (
      .clk_i,
      .en_i   (en),
      .mode_i (mode_e'(mode_i)),
      .vx_i   (in_x_i),
      .vy_i   (in_y_i),
      .vz_i   (in_z_i),
      .vw_i   (in_w_i),
      .m1_i   (cfg_q[0 + c / 2][32 * (c % 2) +: 32]),
      .m2_i   (cfg_q[2 + c / 2][32 * (c % 2) +: 32]),
      .m3_i   (cfg_q[4 + c / 2][32 * (c % 2) +: 32]),
      .m4_i   (cfg_q[6 + c / 2][32 * (c % 2) +: 32]),
      .mode_o (lane_mode[c]),
      .col_o  (col[c])
    );
  end

  vtc_merge u_merge (
    .clk_i,
    .en_i   (en),
    .mode_i (lane_mode[0]),
    .x_i    (col[0]),
    .y_i    (col[1]),
    .z_i    (col[2]),
    .w_i    (col[3]),
    .x_o    (out_x_o),
    .y_o    (out_y_o),
    .z_o    (out_z_o),
    .w_o    (out_w_o)
  );

endmodule

### src/vtc_lane.sv
// one column lane: 3 or 4 products, then up to 3 sums, one per stage
`timescale 1ns / 1ps
module vtc_lane import vtc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  mode_e       mode_i,
  input  logic [31:0] vx_i,
  input  logic [31:0] vy_i,
  input  logic [31:0] vz_i,
  input  logic [31:0] vw_i,
  input  logic [31:0] m1_i,
  input  logic [31:0] m2_i,
  input  logic [31:0] m3_i,
  input  logic [31:0] m4_i,
  output mode_e       mode_o,
  output logic [31:0] col_o
);

  logic [31:0] p1_q, p2_q, p3_q, p4_q, p3b_q, p4b_q, p4c_q, s12_q, s123_q, col_q;
  mode_e       mode1_q, mode2_q, mode3_q, mode4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= fp_mul(vx_i, m1_i);
      p2_q    <= fp_mul(vy_i, m2_i);
      p3_q    <= fp_mul(vz_i, m3_i);
      p4_q    <= (mode_i == MODE_FULL) ? fp_mul(vw_i, m4_i) : m4_i;
      mode1_q <= mode_i;
      s12_q   <= fp_add(p1_q, p2_q);
      p3b_q   <= p3_q;
      p4b_q   <= p4_q;
      mode2_q <= mode1_q;
      s123_q  <= fp_add(s12_q, p3b_q);
      p4c_q   <= p4b_q;
      mode3_q <= mode2_q;
      col_q   <= (mode3_q == MODE_DIR) ? s123_q : fp_add(s123_q, p4c_q);
      mode4_q <= mode3_q;
    end
  end

  assign col_o  = col_q;
  assign mode_o = mode4_q;

endmodule

### src/vtc_div.sv
// pipelined binary32 divider, one quotient bit per stage
`timescale 1ns / 1ps
module vtc_div import vtc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  logic                      sgn_q  [DIV_STEPS+1];
  logic                      spec_q [DIV_STEPS+1];
  logic [31:0]               sval_q [DIV_STEPS+1];
  logic signed [11:0]        exp_q  [DIV_STEPS+1];
  logic [24:0]               rem_q  [DIV_STEPS+1];
  logic [23:0]               dvs_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]      quo_q  [DIV_STEPS+1];
  logic [31:0]               y_q;

  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, s;
  logic [23:0] ma, mb;
  logic [4:0]  lza, lzb;
  logic [7:0]  exa, exb;
  logic        fa, fb;
  logic        spec_d;
  logic [31:0] sval_d;

  always_comb begin
    s      = a_i[31] ^ b_i[31];
    nan_a  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'b0);
    nan_b  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'b0);
    inf_a  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'b0);
    inf_b  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'b0);
    zero_a = a_i[30:0] == 31'b0;
    zero_b = b_i[30:0] == 31'b0;
    exa    = (a_i[30:23] == 8'h00) ? 8'd1 : a_i[30:23];
    exb    = (b_i[30:23] == 8'h00) ? 8'd1 : b_i[30:23];
    ma     = {(a_i[30:23] != 8'h00), a_i[22:0]};
    mb     = {(b_i[30:23] != 8'h00), b_i[22:0]};
    lza    = '0;
    lzb    = '0;
    fa     = 1'b0;
    fb     = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!fa) begin
        if (ma[i]) fa = 1'b1;
        else lza = lza + 5'd1;
      end
      if (!fb) begin
        if (mb[i]) fb = 1'b1;
        else lzb = lzb + 5'd1;
      end
    end
    spec_d = 1'b1;
    if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) sval_d = QNAN;
    else if (inf_a || zero_b) sval_d = {s, 8'hFF, 23'b0};
    else if (inf_b || zero_a) sval_d = {s, 31'b0};
    else begin
      sval_d = '0;
      spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn_q[0]  <= s;
      spec_q[0] <= spec_d;
      sval_q[0] <= sval_d;
      exp_q[0]  <= $signed({4'b0, exa}) - $signed({7'b0, lza})
                 - $signed({4'b0, exb}) + $signed({7'b0, lzb}) + 12'sd127;
      rem_q[0]  <= {1'b0, ma << lza};
      dvs_q[0]  <= mb << lzb;
      quo_q[0]  <= '0;
      for (int g = 0; g < DIV_STEPS; g++) begin
        sgn_q[g+1]  <= sgn_q[g];
        spec_q[g+1] <= spec_q[g];
        sval_q[g+1] <= sval_q[g];
        exp_q[g+1]  <= exp_q[g];
        dvs_q[g+1]  <= dvs_q[g];
        if (rem_q[g] >= {1'b0, dvs_q[g]}) begin
          rem_q[g+1] <= {rem_q[g][23:0] - dvs_q[g], 1'b0};
          quo_q[g+1] <= {quo_q[g][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_q[g+1] <= {rem_q[g][23:0], 1'b0};
          quo_q[g+1] <= {quo_q[g][DIV_STEPS-2:0], 1'b0};
        end
      end
      y_q <= spec_q[DIV_STEPS] ? sval_q[DIV_STEPS]
           : fp_round(sgn_q[DIV_STEPS], exp_q[DIV_STEPS],
                      {quo_q[DIV_STEPS], |rem_q[DIV_STEPS], 22'b0});
    end
  end

  assign y_o = y_q;

endmodule

### src/vtc_merge.sv
// merge of the four lane results: perspective divide and mode selection
`timescale 1ns / 1ps
module vtc_merge import vtc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  mode_e       mode_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  logic [31:0] w_i,
  output logic [31:0] x_o,
  output logic [31:0] y_o,
  output logic [31:0] z_o,
  output logic [31:0] w_o
);

  mode_e       mode_q [DIV_LAT];
  logic [31:0] x_q [DIV_LAT];
  logic [31:0] y_q [DIV_LAT];
  logic [31:0] z_q [DIV_LAT];
  logic [31:0] w_q [DIV_LAT];
  logic [31:0] qx, qy, qz;
  logic        do_div;

  vtc_div u_div_x (.clk_i, .en_i, .a_i(x_i), .b_i(w_i), .y_o(qx));
  vtc_div u_div_y (.clk_i, .en_i, .a_i(y_i), .b_i(w_i), .y_o(qy));
  vtc_div u_div_z (.clk_i, .en_i, .a_i(z_i), .b_i(w_i), .y_o(qz));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q[0] <= mode_i;
      x_q[0]    <= x_i;
      y_q[0]    <= y_i;
      z_q[0]    <= z_i;
      w_q[0]    <= w_i;
      for (int k = 1; k < DIV_LAT; k++) begin
        mode_q[k] <= mode_q[k-1];
        x_q[k]    <= x_q[k-1];
        y_q[k]    <= y_q[k-1];
        z_q[k]    <= z_q[k-1];
        w_q[k]    <= w_q[k-1];
      end
    end
  end

  assign do_div = (mode_q[DIV_LAT-1] == MODE_DIVIDE) && (w_q[DIV_LAT-1][30:0] != 31'b0);
  assign x_o    = do_div ? qx : x_q[DIV_LAT-1];
  assign y_o    = do_div ? qy : y_q[DIV_LAT-1];
  assign z_o    = do_div ? qz : z_q[DIV_LAT-1];
  assign w_o    = (mode_q[DIV_LAT-1] == MODE_DIR) ? 32'b0 : w_q[DIV_LAT-1];

endmodule
